### hdl/pcc_pkg.sv
// pcc_pkg: shared types and constants for the polar/cartesian CORDIC converter.
// Holds the per-stage arctangent table, gain constants and request control struct.
// No dependencies.
`timescale 1ns / 1ps

package pcc_pkg;

    // opcode values
    localparam logic OP_TO_CART  = 1'b0;
    localparam logic OP_TO_POLAR = 1'b1;

    // coordinates carry this many fraction bits through the stages
    localparam int FRAC_BITS = 14;

    // gain 0.6072529350 in Q30, split into high and low 15-bit halves
    localparam logic [14:0] GAIN_HI = 15'd19898;
    localparam logic [14:0] GAIN_LO = 15'd15210;

    // half turn in the 32-bit angle unit
    localparam logic [31:0] HALF_TURN = 32'h8000_0000;

    // atan(2^-i), 2^32 units per full turn, rounded
    localparam logic [31:0] ATAN_TABLE [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    // control that travels with each request down the pipeline
    typedef struct packed {
        logic vec;     // 1: vectoring (cartesian to polar), 0: rotation
        logic origin;  // cartesian input was the origin
    } t_ctrl;

endpackage

### hdl/pcc_prep.sv
// pcc_prep: front-end stage of the converter; registers a request and folds the
// vector into the right half plane before the CORDIC cells.
// Depends on pcc_pkg.
`timescale 1ns / 1ps

module pcc_prep
    import pcc_pkg::*;
#(
    parameter int W  = 16,
    parameter int DW = 33
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 i_opcode,
    input  logic signed [W-1:0]  i_coord_x,
    input  logic signed [W-1:0]  i_coord_y,
    input  logic        [W-2:0]  i_magnitude,
    input  logic signed [W-1:0]  i_angle,
    input  logic                 i_ready,
    output logic                 o_ready,
    output logic                 o_valid,
    output t_ctrl                o_ctrl,
    output logic signed [DW-1:0] o_x,
    output logic signed [DW-1:0] o_y,
    output logic        [31:0]   o_z
);

    localparam int UP = 32 - W;

    logic                 r_valid;
    t_ctrl                r_ctrl;
    t_ctrl                n_ctrl;
    logic signed [DW-1:0] r_x, r_y, n_x, n_y;
    logic        [31:0]   r_z, n_z;

    logic signed [DW-1:0] rx, cx, cy;
    logic        [31:0]   za;
    logic                 quad;

    always_comb begin
        rx   = DW'(signed'({1'b0, i_magnitude}));
        cx   = DW'(i_coord_x);
        cy   = DW'(i_coord_y);
        za   = 32'(i_angle) << UP;
        quad = za[31] ^ za[30];

        n_ctrl.vec    = (i_opcode == OP_TO_POLAR);
        n_ctrl.origin = (i_coord_x == '0) && (i_coord_y == '0);

        if (i_opcode == OP_TO_POLAR) begin
            // turn by pi when x is negative
            if (i_coord_x[W-1]) begin
                n_x = (-cx) <<< FRAC_BITS;
                n_y = (-cy) <<< FRAC_BITS;
                n_z = HALF_TURN;
            end else begin
                n_x = cx <<< FRAC_BITS;
                n_y = cy <<< FRAC_BITS;
                n_z = '0;
            end
        end else begin
            // turn by pi when the angle lies beyond a quarter turn
            n_y = '0;
            if (quad) begin
                n_x = (-rx) <<< FRAC_BITS;
                n_z = za + HALF_TURN;
            end else begin
                n_x = rx <<< FRAC_BITS;
                n_z = za;
            end
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_ctrl <= n_ctrl;
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
        end
    end

    assign o_valid = r_valid;
    assign o_ctrl  = r_ctrl;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;

endmodule

### hdl/pcc_cell.sv
// pcc_cell: one circular CORDIC micro-rotation, registered, with its own valid.
// Serves both rotation and vectoring mode; STAGE selects shift and angle step.
// Depends on pcc_pkg.
`timescale 1ns / 1ps

module pcc_cell
    import pcc_pkg::*;
#(
    parameter int DW    = 33,
    parameter int STAGE = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  t_ctrl                i_ctrl,
    input  logic signed [DW-1:0] i_x,
    input  logic signed [DW-1:0] i_y,
    input  logic        [31:0]   i_z,
    input  logic                 i_ready,
    output logic                 o_ready,
    output logic                 o_valid,
    output t_ctrl                o_ctrl,
    output logic signed [DW-1:0] o_x,
    output logic signed [DW-1:0] o_y,
    output logic        [31:0]   o_z
);

    localparam logic [31:0] STEP = ATAN_TABLE[STAGE];

    logic                 r_valid;
    t_ctrl                r_ctrl;
    logic signed [DW-1:0] r_x, r_y, n_x, n_y;
    logic        [31:0]   r_z, n_z;
    logic signed [DW-1:0] xs, ys;
    logic                 ccw;

    always_comb begin
        xs  = i_x >>> STAGE;
        ys  = i_y >>> STAGE;
        // vectoring drives y to zero, rotation drives z to zero
        ccw = i_ctrl.vec ? i_y[DW-1] : ~i_z[31];
        if (ccw) begin
            n_x = i_x - ys;
            n_y = i_y + xs;
            n_z = i_z - STEP;
        end else begin
            n_x = i_x + ys;
            n_y = i_y - xs;
            n_z = i_z + STEP;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_ctrl <= i_ctrl;
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
        end
    end

    assign o_valid = r_valid;
    assign o_ctrl  = r_ctrl;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;

endmodule

### hdl/pcc_comp.sv
// pcc_comp: gain compensation and result formatting, two registered stages.
// Stage one forms the gain products, stage two rounds, saturates and drives outputs.
// Depends on pcc_pkg.
`timescale 1ns / 1ps

module pcc_comp
    import pcc_pkg::*;
#(
    parameter int W  = 16,
    parameter int DW = 33
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  t_ctrl                i_ctrl,
    input  logic signed [DW-1:0] i_x,
    input  logic signed [DW-1:0] i_y,
    input  logic        [31:0]   i_z,
    input  logic                 i_ready,
    output logic                 o_ready,
    output logic                 o_valid,
    output logic signed [W-1:0]  o_x,
    output logic signed [W-1:0]  o_y,
    output logic        [W-1:0]  o_magnitude,
    output logic signed [W-1:0]  o_angle
);

    localparam int MW = DW + 16;
    localparam logic signed [MW-1:0] GHI  = MW'(signed'({1'b0, GAIN_HI}));
    localparam logic signed [MW-1:0] GLO  = MW'(signed'({1'b0, GAIN_LO}));
    localparam logic signed [MW-1:0] RND  = MW'(1) <<< (FRAC_BITS + 14);
    localparam logic signed [MW-1:0] SMAX = (MW'(1) <<< (W - 1)) - MW'(1);
    localparam logic signed [MW-1:0] SMIN = -SMAX - MW'(1);
    localparam logic signed [MW-1:0] UMAX = (MW'(1) <<< W) - MW'(1);
    localparam logic        [31:0]   ZRND = (32'd1 << (32 - W)) >> 1;

    // stage one
    logic                 r_v1;
    t_ctrl                r_ctrl;
    logic signed [MW-1:0] r_phx, r_plx, r_phy, r_ply;
    logic        [31:0]   r_z;
    logic                 rdy1;

    // stage two (output register)
    logic                 r_v2;
    logic signed [W-1:0]  r_x, r_y, r_ang, n_x, n_y, n_ang;
    logic        [W-1:0]  r_mag, n_mag;
    logic                 rdy2;

    logic signed [MW-1:0] px, py, qx, qy;
    logic        [31:0]   zr;

    function automatic logic signed [W-1:0] sat_s(input logic signed [MW-1:0] v);
        logic signed [MW-1:0] c;
        begin
            if (v > SMAX) begin
                c = SMAX;
            end else if (v < SMIN) begin
                c = SMIN;
            end else begin
                c = v;
            end
            sat_s = c[W-1:0];
        end
    endfunction

    assign rdy2    = !r_v2 || i_ready;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_ctrl <= i_ctrl;
            r_z    <= i_z;
            r_phx  <= MW'(i_x) * GHI;
            r_plx  <= MW'(i_x) * GLO;
            r_phy  <= MW'(i_y) * GHI;
            r_ply  <= MW'(i_y) * GLO;
        end
    end

    always_comb begin
        px = r_phx + (r_plx >>> 15) + RND;
        py = r_phy + (r_ply >>> 15) + RND;
        qx = px >>> (FRAC_BITS + 15);
        qy = py >>> (FRAC_BITS + 15);
        zr = r_z + ZRND;

        n_x   = '0;
        n_y   = '0;
        n_mag = '0;
        n_ang = '0;
        if (!r_ctrl.vec) begin
            n_x = sat_s(qx);
            n_y = sat_s(qy);
        end else if (!r_ctrl.origin) begin
            if (qx < 0) begin
                n_mag = '0;
            end else if (qx > UMAX) begin
                n_mag = '1;
            end else begin
                n_mag = qx[W-1:0];
            end
            n_ang = zr[31 -: W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_mag <= n_mag;
            r_ang <= n_ang;
        end
    end

    assign o_valid     = r_v2;
    assign o_x         = r_x;
    assign o_y         = r_y;
    assign o_magnitude = r_mag;
    assign o_angle     = r_ang;

endmodule

### hdl/polar_cartesian_converter.sv
// polar_cartesian_converter: top level of the pipelined CORDIC coordinate converter.
// Instantiates pcc_prep, a chain of pcc_cell stages and pcc_comp; uses pcc_pkg.
//
//   channel   direction  handshake               payload
//   request   in         i_in_valid / o_in_stall i_opcode, i_coord_x, i_coord_y,
//                                                i_magnitude, i_angle
//   result    out        o_out_valid/i_out_stall o_out_x, o_out_y, o_out_magnitude,
//                                                o_out_angle
//
// Takes one request per cycle while o_in_stall is low; a request passes one front-end
// register, one register per CORDIC cell and two compensation registers.
// Every stage holds its own valid bit, so bubbles collapse and a stalled result
// only holds back the stages behind it that are full.
// Reset (synchronous, active low) clears only the valid bits; the pipeline is
// empty and ready in the first cycle after reset.
`timescale 1ns / 1ps

module polar_cartesian_converter
    import pcc_pkg::*;
#(
    parameter int COORD_WIDTH   = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_opcode,
    input  logic signed [COORD_WIDTH-1:0]  i_coord_x,
    input  logic signed [COORD_WIDTH-1:0]  i_coord_y,
    input  logic        [COORD_WIDTH-2:0]  i_magnitude,
    input  logic signed [COORD_WIDTH-1:0]  i_angle,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic signed [COORD_WIDTH-1:0]  o_out_x,
    output logic signed [COORD_WIDTH-1:0]  o_out_y,
    output logic        [COORD_WIDTH-1:0]  o_out_magnitude,
    output logic signed [COORD_WIDTH-1:0]  o_out_angle
);

    // cell count; the arctangent table covers 32 stages
    localparam int N  = (CORDIC_STAGES < 32) ? CORDIC_STAGES : 32;
    // datapath width: sign, pi fold, CORDIC growth, fraction bits and margin
    localparam int DW = COORD_WIDTH + FRAC_BITS + 3;

    logic                 w_valid [0:N];
    logic                 w_ready [0:N];
    t_ctrl                w_ctrl  [0:N];
    logic signed [DW-1:0] w_x     [0:N];
    logic signed [DW-1:0] w_y     [0:N];
    logic        [31:0]   w_z     [0:N];

    logic                 comp_ready;
    logic                 prep_ready;

    // hold the request while the front stage is full and cannot advance
    assign o_in_stall = !prep_ready;

    pcc_prep #(
        .W  (COORD_WIDTH),
        .DW (DW)
    ) u_prep (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .i_opcode    (i_opcode),
        .i_coord_x   (i_coord_x),
        .i_coord_y   (i_coord_y),
        .i_magnitude (i_magnitude),
        .i_angle     (i_angle),
        .i_ready     (w_ready[0]),
        .o_ready     (prep_ready),
        .o_valid     (w_valid[0]),
        .o_ctrl      (w_ctrl[0]),
        .o_x         (w_x[0]),
        .o_y         (w_y[0]),
        .o_z         (w_z[0])
    );

    // advance each request one micro-rotation per cell
    for (genvar k = 0; k < N; k++) begin : g_cell
        pcc_cell #(
            .DW    (DW),
            .STAGE (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .i_ctrl  (w_ctrl[k]),
            .i_x     (w_x[k]),
            .i_y     (w_y[k]),
            .i_z     (w_z[k]),
            .i_ready (w_ready[k+1]),
            .o_ready (w_ready[k]),
            .o_valid (w_valid[k+1]),
            .o_ctrl  (w_ctrl[k+1]),
            .o_x     (w_x[k+1]),
            .o_y     (w_y[k+1]),
            .o_z     (w_z[k+1])
        );
    end

    assign w_ready[N] = comp_ready;

    // compensate the CORDIC gain, round and drive the result register
    pcc_comp #(
        .W  (COORD_WIDTH),
        .DW (DW)
    ) u_comp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_valid[N]),
        .i_ctrl      (w_ctrl[N]),
        .i_x         (w_x[N]),
        .i_y         (w_y[N]),
        .i_z         (w_z[N]),
        .i_ready     (!i_out_stall),
        .o_ready     (comp_ready),
        .o_valid     (o_out_valid),
        .o_x         (o_out_x),
        .o_y         (o_out_y),
        .o_magnitude (o_out_magnitude),
        .o_angle     (o_out_angle)
    );

endmodule
